// ----- rtl/dltq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types and constants for the delta list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;
  localparam int unsigned NUM_TIMERS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF  = 32;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned ID_W           = 4;
  localparam int unsigned LOAD_W         = 32;
  localparam int unsigned NOW_W          = 32;
  localparam int unsigned MAX_EXP        = 16;

  localparam logic [OP_W-1:0] OP_START   = 2'd0;
  localparam logic [OP_W-1:0] OP_STOP    = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   timer_id;
    logic [LOAD_W-1:0] load;
    logic              periodic;
    logic [NOW_W-1:0]  now;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0] expired_id;
    logic            expired;
    logic            status;
    logic [31:0]     next_deadline;
    logic            queue_empty;
    logic            last;
  } out_word_t;
endpackage
`default_nettype wire

// ----- rtl/dltq_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_if
// Valid/ready channel that carries one word of type word_t.
// ----------------------------------------------------------------------------
interface dltq_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/dltq_slot_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_slot_mem
// Slot memory: owner and delta per queue slot, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module dltq_slot_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned DW    = 36
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DW-1:0]            wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DW-1:0]            rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/dltq_timer_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_timer_mem
// Per-timer reload memory: reload ticks and the periodic flag.
// ----------------------------------------------------------------------------
module dltq_timer_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned DW    = 33
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DW-1:0]            wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DW-1:0]            rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/delta_list_timer_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Sorted delta queue of software timers held in a slot memory.
// ----------------------------------------------------------------------------
// Usage: commands enter on the in_ channel (start, stop, advance) and results
// leave on the out_ channel, one word per start or stop and one word per
// expiry of an advance (or a single word when nothing expires). The last
// word of a command has last set. One command is processed at a time.
// Every slot access is a read followed by a compare or a write. An advance
// pops each expired head, then reinserts the periodic ones, each as an
// insert. After reset the queue is empty and all timers are idle, with no
// clearing pass. When the receiver stalls, the finished word waits in the
// output register and the engine holds.
// ----------------------------------------------------------------------------
module delta_list_timer_queue #(
  parameter int unsigned NUM_TIMERS = dltq_pkg::NUM_TIMERS_DEF,
  parameter int unsigned TIME_BITS  = dltq_pkg::TIME_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  dltq_if.sink     in_ch,
  dltq_if.source   out_ch
);
  import dltq_pkg::*;

  localparam int unsigned AW = $clog2(NUM_TIMERS);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned SW = AW + TW;
  localparam int unsigned EW = $clog2(MAX_EXP) + 1;
  localparam logic [CW-1:0] FULL = CW'(NUM_TIMERS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_IWALK  = 4'd1;
  localparam logic [3:0] S_ISHIFT = 4'd2;
  localparam logic [3:0] S_RSRCH  = 4'd3;
  localparam logic [3:0] S_RNEXT  = 4'd4;
  localparam logic [3:0] S_RSHIFT = 4'd5;
  localparam logic [3:0] S_AHEAD  = 4'd6;
  localparam logic [3:0] S_RELD   = 4'd7;
  localparam logic [3:0] S_RELD2  = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;
  localparam logic [3:0] S_HEAD   = 4'd11;

  logic [3:0]      state_r;
  logic [CW-1:0]   cnt_r;
  logic [NUM_TIMERS-1:0] active_r;
  logic [CW-1:0]   idx_r;
  logic [TW-1:0]   rem_r;
  logic [AW-1:0]   id_r;
  logic [TW-1:0]   now_r;
  logic [1:0]      ph_r;
  logic [SW-1:0]   carry_r;
  logic [TW-1:0]   head_r;
  logic            status_r;
  logic            adv_r;
  logic [AW-1:0]   list_r [MAX_EXP];
  logic [EW-1:0]   n_r;
  logic [EW-1:0]   k_r;
  logic            inret_r;
  logic            ovalid_r;
  out_word_t       odata_r;

  logic            s_we;
  logic [AW-1:0]   s_wa, s_ra;
  logic [SW-1:0]   s_wd, s_rd;
  logic            t_we;
  logic [AW-1:0]   t_wa, t_ra;
  logic [TW:0]     t_wd, t_rd;

  dltq_slot_mem #(.DEPTH(NUM_TIMERS), .DW(SW)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );
  dltq_timer_mem #(.DEPTH(NUM_TIMERS), .DW(TW + 1)) u_tmr (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
  );

  logic [AW-1:0] rd_own;
  logic [TW-1:0] rd_dl;
  assign rd_own = s_rd[SW-1:TW];
  assign rd_dl  = s_rd[TW-1:0];

  in_word_t iw;
  logic     id_ok;
  logic [AW-1:0] iid;
  logic [TW-1:0] ld;
  assign iw    = in_ch.data;
  assign id_ok = ({28'd0, iw.timer_id} < 32'(NUM_TIMERS));
  assign iid   = AW'(iw.timer_id);
  assign ld    = (TW'(iw.load) == '0) ? TW'(1) : TW'(iw.load);
  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = odata_r;

  // Memory port control is combinational on state; the read address is the
  // slot at idx_r, and its data arrives in the next cycle from the registered read.
  always_comb begin
    s_we = 1'b0; s_wa = idx_r[AW-1:0]; s_wd = '0; s_ra = idx_r[AW-1:0];
    t_we = 1'b0; t_wa = iid; t_wd = {iw.periodic, ld};
    t_ra = '0;
    if (state_r == S_IDLE && in_ch.valid && in_ch.ready &&
        iw.operation == OP_START && id_ok && !active_r[iid]) begin
      t_we = 1'b1;
    end
    if (state_r == S_IDLE) begin
      s_ra = '0;
    end
    if (state_r == S_RELD) begin
      t_ra = list_r[k_r[EW-2:0]];
    end
    if (state_r == S_ISHIFT && ph_r == 2'd1) begin
      s_we = 1'b1; s_wa = idx_r[AW-1:0]; s_wd = carry_r;
    end
    if (state_r == S_IWALK && ph_r == 2'd1 && idx_r < cnt_r && rd_dl >= rem_r) begin
      s_we = 1'b1; s_wa = idx_r[AW-1:0];
      s_wd = {id_r, rem_r};
    end
    if (state_r == S_RNEXT && ph_r == 2'd1) begin
      s_we = 1'b1; s_wa = idx_r[AW-1:0]; s_wd = {rd_own, rd_dl + carry_r[TW-1:0]};
    end
    if (state_r == S_RSHIFT && ph_r == 2'd1) begin
      s_we = 1'b1; s_wa = AW'(idx_r - 1'b1); s_wd = s_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      active_r <= '0;
      ovalid_r <= 1'b0;
      ph_r     <= '0;
      idx_r    <= '0;
      n_r      <= '0;
      k_r      <= '0;
    end else begin
      if (ovalid_r && out_ch.ready && state_r != S_EMIT) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            id_r     <= iid;
            now_r    <= TW'(iw.now);
            status_r <= 1'b0;
            adv_r    <= 1'b0;
            inret_r  <= 1'b0;
            n_r      <= '0;
            k_r      <= '0;
            idx_r    <= '0;
            ph_r     <= '0;
            if (iw.operation == OP_START && id_ok && !active_r[iid]) begin
              active_r[iid] <= 1'b1;
              rem_r   <= TW'(iw.now) + ld;
              state_r <= (cnt_r >= FULL) ? S_HEAD : S_IWALK;
            end else if (iw.operation == OP_STOP && id_ok && active_r[iid]) begin
              active_r[iid] <= 1'b0;
              state_r <= S_RSRCH;
            end else if (iw.operation == OP_ADVANCE) begin
              adv_r   <= 1'b1;
              state_r <= S_AHEAD;
            end else begin
              status_r <= 1'b1;
              state_r  <= S_HEAD;
            end
          end
        end
        // Walk: ph 0 issues read of idx, ph 1 compares.
        S_IWALK: begin
          if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else if (idx_r >= cnt_r) begin
            carry_r <= {id_r, rem_r};
            idx_r <= cnt_r; ph_r <= 2'd1;
            state_r <= S_ISHIFT;
          end else if (rd_dl >= rem_r) begin
            // New entry written at idx; displaced entry carried to idx+1.
            carry_r <= {rd_own, rd_dl - rem_r};
            idx_r   <= idx_r + 1'b1;
            ph_r    <= 2'd0;
            state_r <= S_ISHIFT;
          end else begin
            rem_r <= rem_r - rd_dl;
            idx_r <= idx_r + 1'b1;
            ph_r  <= 2'd0;
          end
        end
        // Shift: read idx (ph 0), then write carry at idx and keep old.
        S_ISHIFT: begin
          if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else begin
            carry_r <= s_rd;
            if (idx_r >= cnt_r) begin
              cnt_r   <= cnt_r + 1'b1;
              state_r <= inret_r ? S_RELD : S_HEAD;
              k_r     <= inret_r ? k_r + 1'b1 : k_r;
              ph_r    <= '0;
              idx_r   <= '0;
            end else begin
              idx_r <= idx_r + 1'b1;
              ph_r  <= 2'd0;
            end
          end
        end
        S_RSRCH: begin
          if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else if (idx_r >= cnt_r) begin
            state_r <= S_HEAD; ph_r <= '0; idx_r <= '0;
          end else if (rd_own == id_r) begin
            carry_r <= s_rd;
            idx_r   <= idx_r + 1'b1;
            ph_r    <= 2'd0;
            state_r <= S_RNEXT;
          end else begin
            idx_r <= idx_r + 1'b1; ph_r <= 2'd0;
          end
        end
        // Add removed delta into the successor (in place), then shift down.
        S_RNEXT: begin
          if (idx_r >= cnt_r) begin
            cnt_r <= cnt_r - 1'b1; ph_r <= '0;
            state_r <= adv_r ? S_AHEAD : S_HEAD;
            idx_r <= '0;
          end else if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else if (ph_r == 2'd1) begin
            ph_r <= 2'd2;
          end else begin
            ph_r <= 2'd0; state_r <= S_RSHIFT;
          end
        end
        S_RSHIFT: begin
          if (idx_r >= cnt_r) begin
            cnt_r <= cnt_r - 1'b1; ph_r <= '0;
            state_r <= adv_r ? S_AHEAD : S_HEAD;
            idx_r <= '0;
          end else if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else begin
            idx_r <= idx_r + 1'b1; ph_r <= 2'd0;
          end
        end
        S_AHEAD: begin
          if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else if (cnt_r != '0 && n_r < EW'(MAX_EXP) && rd_dl <= now_r) begin
            list_r[n_r[EW-2:0]] <= rd_own;
            active_r[rd_own] <= 1'b0;
            n_r     <= n_r + 1'b1;
            carry_r <= s_rd;
            idx_r   <= CW'(1);
            ph_r    <= 2'd0;
            state_r <= S_RNEXT;
          end else begin
            ph_r <= '0; k_r <= '0;
            state_r <= S_RELD;
          end
        end
        S_RELD: begin
          if (k_r >= n_r) begin
            k_r <= '0; state_r <= S_HEAD; ph_r <= '0;
          end else begin
            state_r <= S_RELD2;
          end
        end
        S_RELD2: begin
          if (t_rd[TW] && cnt_r < FULL) begin
            active_r[list_r[k_r[EW-2:0]]] <= 1'b1;
            id_r    <= list_r[k_r[EW-2:0]];
            rem_r   <= now_r + t_rd[TW-1:0];
            inret_r <= 1'b1;
            idx_r   <= '0; ph_r <= '0;
            state_r <= S_IWALK;
          end else begin
            if (t_rd[TW]) begin
              active_r[list_r[k_r[EW-2:0]]] <= 1'b1;
            end
            k_r <= k_r + 1'b1;
            state_r <= S_RELD;
          end
        end
        S_HEAD: begin
          if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else begin
            head_r <= rd_dl; ph_r <= '0; k_r <= '0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!ovalid_r || out_ch.ready) begin
            ovalid_r <= 1'b1;
            odata_r.expired_id <= (n_r != '0) ? ID_W'(list_r[k_r[EW-2:0]]) : '0;
            odata_r.expired    <= (n_r != '0);
            odata_r.status     <= status_r;
            odata_r.next_deadline <= (cnt_r != '0) ? 32'(head_r) : '0;
            odata_r.queue_empty   <= (cnt_r == '0);
            if (n_r == '0 || k_r + 1'b1 >= n_r) begin
              odata_r.last <= 1'b1;
              state_r <= S_OUT;
            end else begin
              odata_r.last <= 1'b0;
              k_r <= k_r + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!ovalid_r || out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Read address for walks: the slot currently indexed.
  // (S_IDLE forces slot zero; head reads use slot zero through idx_r cleared.)

  property p_cnt_bound;
    @(posedge clk) disable iff (!rst_n) cnt_r <= FULL;
  endproperty
  assert property (p_cnt_bound) else $error("queue count overflow");

  property p_ready_idle;
    @(posedge clk) disable iff (!rst_n) in_ch.ready |-> state_r == S_IDLE;
  endproperty
  assert property (p_ready_idle) else $error("ready outside idle");

  property p_exp_bound;
    @(posedge clk) disable iff (!rst_n) n_r <= EW'(MAX_EXP);
  endproperty
  assert property (p_exp_bound) else $error("too many expiries");
endmodule
`default_nettype wire

// ----- tb/dltq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltq_checker
// Watches the command and result channels of the timer queue, keeps its own
// delta list of timers, and compares every result word with the oldest
// predicted word, field by field.
// ----------------------------------------------------------------------------
module dltq_checker
  import dltq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_word,
  output int        failures,
  output int        outstanding
);
  localparam int unsigned SLOTS = 16;

  logic [ID_W-1:0] slot_timer [SLOTS];
  logic [31:0]     slot_gap   [SLOTS];
  int unsigned     queued;
  logic [31:0]     reload_len [SLOTS];
  logic            reloads    [SLOTS];
  logic            running    [SLOTS];
  out_word_t       due_words [$];
  int              fail_count = 0;

  assign failures    = fail_count;
  assign outstanding = due_words.size();

  task automatic link_timer(input logic [ID_W-1:0] id, input logic [31:0] deadline);
    logic [31:0] rem;
    int unsigned pos;
    rem = deadline;
    pos = queued;
    if (queued >= SLOTS) return;
    for (int unsigned i = 0; i < queued; i++) begin
      if (slot_gap[i] >= rem) begin
        slot_gap[i] = slot_gap[i] - rem;
        pos = i;
        break;
      end
      rem = rem - slot_gap[i];
    end
    for (int unsigned i = queued; i > pos; i--) begin
      slot_timer[i] = slot_timer[i-1];
      slot_gap[i]   = slot_gap[i-1];
    end
    slot_timer[pos] = id;
    slot_gap[pos]   = rem;
    queued++;
  endtask

  task automatic unlink_slot(input int unsigned pos);
    if (pos >= queued) return;
    if (pos + 1 < queued) slot_gap[pos+1] = slot_gap[pos+1] + slot_gap[pos];
    for (int unsigned i = pos; i + 1 < queued; i++) begin
      slot_timer[i] = slot_timer[i+1];
      slot_gap[i]   = slot_gap[i+1];
    end
    queued--;
  endtask

  task automatic add_due(input logic [ID_W-1:0] id, input logic fired, input logic ignored,
                         input logic final_word);
    out_word_t w;
    w.expired_id    = id;
    w.expired       = fired;
    w.status        = ignored;
    w.next_deadline = (queued != 0) ? slot_gap[0] : 32'd0;
    w.queue_empty   = (queued == 0);
    w.last          = final_word;
    due_words.push_back(w);
  endtask

  task automatic run_command(input in_word_t c);
    logic [ID_W-1:0] fired [MAX_EXP];
    int unsigned     n;
    logic [31:0]     ticks;
    n = 0;
    case (c.operation)
      OP_START: begin
        if (running[c.timer_id]) begin
          add_due('0, 1'b0, 1'b1, 1'b1);
        end else begin
          ticks = (c.load == 0) ? 32'd1 : c.load;
          reload_len[c.timer_id] = ticks;
          reloads[c.timer_id]    = c.periodic;
          running[c.timer_id]    = 1'b1;
          link_timer(c.timer_id, c.now + ticks);
          add_due('0, 1'b0, 1'b0, 1'b1);
        end
      end
      OP_STOP: begin
        if (!running[c.timer_id]) begin
          add_due('0, 1'b0, 1'b1, 1'b1);
        end else begin
          running[c.timer_id] = 1'b0;
          for (int unsigned i = 0; i < queued; i++) begin
            if (slot_timer[i] == c.timer_id) begin
              unlink_slot(i);
              break;
            end
          end
          add_due('0, 1'b0, 1'b0, 1'b1);
        end
      end
      OP_ADVANCE: begin
        while (queued > 0 && n < MAX_EXP && slot_gap[0] <= c.now) begin
          fired[n] = slot_timer[0];
          unlink_slot(0);
          running[fired[n]] = 1'b0;
          n++;
        end
        for (int unsigned i = 0; i < n; i++) begin
          if (reloads[fired[i]]) begin
            running[fired[i]] = 1'b1;
            link_timer(fired[i], c.now + reload_len[fired[i]]);
          end
        end
        if (n == 0) add_due('0, 1'b0, 1'b0, 1'b1);
        for (int unsigned i = 0; i < n; i++) add_due(fired[i], 1'b1, 1'b0, i + 1 == n);
      end
      default: add_due('0, 1'b0, 1'b1, 1'b1);
    endcase
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (due_words.size() == 0) begin
      $error("unexpected result word %h", got);
      fail_count++;
      return;
    end
    want = due_words.pop_front();
    if (got.expired_id !== want.expired_id) begin
      $error("expired_id: expected %0d, got %0d", want.expired_id, got.expired_id);
      fail_count++;
    end
    if (got.expired !== want.expired) begin
      $error("expired: expected %0d, got %0d", want.expired, got.expired);
      fail_count++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.next_deadline !== want.next_deadline) begin
      $error("next_deadline: expected %0d, got %0d", want.next_deadline, got.next_deadline);
      fail_count++;
    end
    if (got.queue_empty !== want.queue_empty) begin
      $error("queue_empty: expected %0d, got %0d", want.queue_empty, got.queue_empty);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      queued = 0;
      for (int i = 0; i < SLOTS; i++) running[i] = 1'b0;
      due_words.delete();
    end else begin
      if (out_valid && out_ready) check_word(out_word);
      if (in_valid && in_ready) run_command(in_word);
    end
  end
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives start, stop, advance and unused commands into the timer queue with random
// gaps and result stalls; a checker beside the block predicts and compares
// every result word. Directed corner cases come first, then random traffic.
// ----------------------------------------------------------------------------
module tb;
  import dltq_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        gaps_on;
  int          stall_left;
  int          fail_total;
  int          pending;
  longint      cycles;
  logic [31:0] tick;

  dltq_if #(.word_t(in_word_t))  in_ch ();
  dltq_if #(.word_t(out_word_t)) out_ch ();

  delta_list_timer_queue uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dltq_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_word     (in_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_word    (out_ch.data),
    .failures    (fail_total),
    .outstanding (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                      input logic [31:0] load, input logic per, input logic [31:0] now);
    in_word_t w;
    int       gap;
    w.operation = op;
    w.timer_id  = id;
    w.load      = load;
    w.periodic  = per;
    w.now       = now;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_load();
    case ($urandom_range(0, 19))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  initial begin
    int sel;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_n       = 1'b0;
    gaps_on     = 1'b1;
    tick        = 32'd100;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(OP_ADVANCE, 4'd0, 32'd0, 1'b0, 32'd0);
    send(OP_STOP, 4'd5, 32'd0, 1'b0, 32'd0);
    send(OP_START, 4'd0, 32'd0, 1'b0, 32'd0);
    send(OP_START, 4'd0, 32'd7, 1'b1, 32'd0);
    send(OP_START, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send(OP_UNUSED, 4'd9, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send(OP_ADVANCE, 4'd0, 32'd0, 1'b0, 32'd1);
    send(OP_STOP, 4'd15, 32'd0, 1'b0, 32'd0);
    send(OP_STOP, 4'd15, 32'd0, 1'b0, 32'd0);
    for (int i = 0; i < 16; i++) send(OP_START, i[3:0], 32'd10 + (i % 5), i[0], 32'd50);
    send(OP_ADVANCE, 4'd0, 32'd0, 1'b0, 32'd80);
    send(OP_ADVANCE, 4'd0, 32'd0, 1'b0, 32'd200);

    for (int n = 0; n < 95; n++) begin
      if (n % 30 == 0) gaps_on = 1'($urandom_range(0, 1));
      if (n >= 80) gaps_on = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        send(OP_START, 4'($urandom_range(0, 15)), pick_load(),
             1'($urandom_range(0, 1)), tick);
      end else if (sel < 65) begin
        send(OP_STOP, 4'($urandom_range(0, 15)), $urandom,
             1'($urandom_range(0, 1)), $urandom);
      end else if (sel < 95) begin
        tick = tick + $urandom_range(0, 40);
        send(OP_ADVANCE, 4'($urandom_range(0, 15)), $urandom, 1'($urandom_range(0, 1)),
             ($urandom_range(0, 19) == 0) ? $urandom : tick);
      end else begin
        send(OP_UNUSED, 4'($urandom_range(0, 15)), $urandom,
             1'($urandom_range(0, 1)), $urandom);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_total == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
